[rtl/ocr_pkg.sv]
`default_nettype none

package ocr_pkg;

   // Sizing
   localparam int MAX_TASKS      = 1024;
   localparam int REORDER_WINDOW = 8;
   localparam int COORD_BITS     = 16;
   localparam int TASK_W         = $clog2(MAX_TASKS);
   localparam int CNT_W          = 11;
   localparam int COUNT_MAX      = 2047;
   localparam int OFF_W          = $clog2(REORDER_WINDOW + 1);
   localparam int SLOT_W         = (REORDER_WINDOW > 1) ? $clog2(REORDER_WINDOW) : 1;
   localparam int BOX_W          = 4 * COORD_BITS;

   typedef enum logic [1:0] {
      OP_BEGIN   = 2'd0,
      OP_LOAD    = 2'd1,
      OP_MARK    = 2'd2,
      OP_CONSUME = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      OUT_TASK    = 2'd0,
      OUT_NONE    = 2'd1,
      OUT_RANGE   = 2'd2,
      OUT_ACCEPT  = 2'd3
   } outcome_type;

   typedef enum logic [1:0] {
      ST_RENDERING = 2'd0,
      ST_RENDERED  = 2'd1,
      ST_COLLECTED = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SKIP_RD,
      S_SKIP_CHK,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_DONE
   } state_type;

   typedef struct packed {
      op_type              operation;
      logic [9:0]          task_index;
      logic [10:0]         frame_task_count;
      logic signed [15:0]  box_left;
      logic signed [15:0]  box_top;
      logic signed [15:0]  box_right;
      logic signed [15:0]  box_bottom;
   } req_type;

   typedef struct packed {
      outcome_type outcome;
      logic [9:0]  collected_task;
      logic        was_reordered;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] bottom;
      logic signed [COORD_BITS-1:0] right;
      logic signed [COORD_BITS-1:0] top;
      logic signed [COORD_BITS-1:0] left;
   } box_type;

   // Window buffer control
   typedef struct packed {
      logic              store;
      logic [SLOT_W-1:0] slot;
      logic [OFF_W-1:0]  count;
   } win_ctl_type;

endpackage

`default_nettype wire

[rtl/ocr_ram.sv]
`default_nettype none

module ocr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[rtl/ocr_window.sv]
`default_nettype none

module ocr_window
   import ocr_pkg::*;
(
   input  wire logic        clock,
   input  wire win_ctl_type ctl,
   input  wire box_type     box,
   output logic             overlap
);

   box_type slot_ff [REORDER_WINDOW];

   function automatic logic boxes_hit(input box_type a, input box_type b);
      return (a.left < b.right) && (b.left < a.right) &&
             (a.top < b.bottom) && (b.top < a.bottom);
   endfunction

   // boxes of the window entries scanned so far
   always_ff @(posedge clock) begin
      if (ctl.store) begin
         slot_ff[ctl.slot] <= box;
      end
   end

   // candidate against every filled slot
   always_comb begin
      overlap = 1'b0;
      for (int k = 0; k < REORDER_WINDOW; k++) begin
         if ((OFF_W'(k) < ctl.count) && boxes_hit(slot_ff[k], box)) begin
            overlap = 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

[rtl/overlap_aware_reorder_collector.sv]
// Reorder collector: commands arrive as words on req_ and each produces one rsp_ word.
// Task status (1024 x 2 bits) and boxes (1024 x 64 bits) live in two synchronous RAMs.
// A box load or mark goes from accept straight to the answer. A consume reads
// head entries, skipping collected entries one at a time, then scans window
// entries, at most REORDER_WINDOW entries, each compared in parallel against
// the boxes already seen.
// Begin frame and reset run a clearing sweep of the status RAM, one entry a cycle
// over all 1024 entries, during which no word is taken; begin frame answers after
// the sweep. Every result may wait further while rsp_stall holds the previous one.
// A new word is taken while a result still waits on rsp_.
`default_nettype none

module overlap_aware_reorder_collector
   import ocr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_word,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_word
);

   state_type        state_ff, state_in;
   logic [TASK_W-1:0] clr_ff, clr_in;
   logic             clr_rsp_ff, clr_rsp_in;
   logic [CNT_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] rcnt_ff, rcnt_in;
   logic [CNT_W-1:0] active_ff, active_in;
   logic [OFF_W-1:0] off_ff, off_in;
   rsp_type          res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic              accept;
   logic              head_oob, in_window, scan_stop, out_free, clr_last, overlap;
   logic [CNT_W:0]    win_end, scan_addr;
   status_type        st_rd;
   box_type           box_rd, box_wr;
   logic              st_we, st_re, box_we, box_re;
   logic [TASK_W-1:0] st_waddr, st_raddr, box_waddr;
   status_type        st_wdata;
   logic [1:0]        st_rdata;
   logic [BOX_W-1:0]  box_rdata;
   win_ctl_type       win_ctl;

   ocr_ram #(.WIDTH(2), .DEPTH(MAX_TASKS)) u_status (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_en   (st_re),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   ocr_ram #(.WIDTH(BOX_W), .DEPTH(MAX_TASKS)) u_box (
      .clock   (clock),
      .wr_en   (box_we),
      .wr_addr (box_waddr),
      .wr_data (box_wr),
      .rd_en   (box_re),
      .rd_addr (scan_addr[TASK_W-1:0]),
      .rd_data (box_rdata)
   );

   ocr_window u_window (
      .clock   (clock),
      .ctl     (win_ctl),
      .box     (box_rd),
      .overlap (overlap)
   );

   // shared decisions
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign head_oob  = (head_ff >= active_ff);
   assign win_end   = {1'b0, head_ff} + (CNT_W+1)'(REORDER_WINDOW);
   assign in_window = (rcnt_ff > head_ff) && ({1'b0, rcnt_ff} <= win_end);
   assign scan_addr = {1'b0, head_ff} + (CNT_W+1)'(off_ff);
   assign scan_stop = (off_ff >= OFF_W'(REORDER_WINDOW)) || (scan_addr >= {1'b0, active_ff});
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign clr_last  = (clr_ff == TASK_W'(MAX_TASKS - 1));
   assign st_rd     = status_type'(st_rdata);
   assign box_rd    = box_type'(box_rdata);
   assign box_wr    = '{bottom: req_word.box_bottom, right: req_word.box_right,
                        top: req_word.box_top, left: req_word.box_left};
   assign box_waddr = req_word.task_index;

   assign win_ctl.store = (state_ff == S_SCAN_CHK) && (st_rd != ST_RENDERED);
   assign win_ctl.slot  = off_ff[SLOT_W-1:0];
   assign win_ctl.count = off_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_last) state_in = clr_rsp_ff ? S_DONE : S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               unique case (req_word.operation)
                  OP_BEGIN:   state_in = S_CLEAR;
                  OP_CONSUME: state_in = S_SKIP_RD;
                  default:    state_in = S_DONE;
               endcase
            end
         end
         S_SKIP_RD: state_in = head_oob ? S_DONE : S_SKIP_CHK;
         S_SKIP_CHK: begin
            case (st_rd)
               ST_COLLECTED: state_in = S_SKIP_RD;
               ST_RENDERED:  state_in = S_DONE;
               default:      state_in = in_window ? S_SCAN_RD : S_DONE;
            endcase
         end
         S_SCAN_RD:  state_in = scan_stop ? S_DONE : S_SCAN_CHK;
         S_SCAN_CHK: state_in = (st_rd == ST_RENDERED) ? S_DONE : S_SCAN_RD;
         S_DONE:     if (out_free) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      clr_in       = clr_ff;
      clr_rsp_in   = clr_rsp_ff;
      head_in      = head_ff;
      rcnt_in      = rcnt_ff;
      active_in    = active_ff;
      off_in       = off_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      st_we        = 1'b0;
      st_waddr     = head_ff[TASK_W-1:0];
      st_wdata     = ST_COLLECTED;
      st_re        = 1'b0;
      st_raddr     = head_ff[TASK_W-1:0];
      box_we       = 1'b0;
      box_re       = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            st_we    = 1'b1;
            st_waddr = clr_ff;
            st_wdata = ST_RENDERING;
            clr_in   = clr_ff + 1'b1;
         end
         S_IDLE: begin
            res_in = '{outcome: OUT_ACCEPT, collected_task: '0, was_reordered: 1'b0};
            if (accept) begin
               unique case (req_word.operation)
                  OP_BEGIN: begin
                     active_in  = (req_word.frame_task_count > CNT_W'(MAX_TASKS)) ?
                                  CNT_W'(MAX_TASKS) : req_word.frame_task_count;
                     head_in    = '0;
                     rcnt_in    = '0;
                     clr_in     = '0;
                     clr_rsp_in = 1'b1;
                  end
                  OP_LOAD: box_we = 1'b1;
                  OP_MARK: begin
                     if (CNT_W'(req_word.task_index) < active_ff) begin
                        st_we    = 1'b1;
                        st_waddr = req_word.task_index;
                        st_wdata = ST_RENDERED;
                        if (rcnt_ff != CNT_W'(COUNT_MAX)) rcnt_in = rcnt_ff + 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SKIP_RD: begin
            if (head_oob) res_in.outcome = OUT_RANGE;
            else st_re = 1'b1;
         end
         S_SKIP_CHK: begin
            off_in = '0;
            case (st_rd)
               ST_COLLECTED: head_in = head_ff + 1'b1;
               ST_RENDERED: begin
                  st_we  = 1'b1;
                  head_in = head_ff + 1'b1;
                  res_in  = '{outcome: OUT_TASK, collected_task: head_ff[9:0],
                              was_reordered: 1'b0};
               end
               default: res_in.outcome = OUT_NONE;
            endcase
         end
         S_SCAN_RD: begin
            if (!scan_stop) begin
               st_re    = 1'b1;
               st_raddr = scan_addr[TASK_W-1:0];
               box_re   = 1'b1;
            end
         end
         S_SCAN_CHK: begin
            if (st_rd == ST_RENDERED) begin
               if (!overlap) begin
                  st_we    = 1'b1;
                  st_waddr = scan_addr[TASK_W-1:0];
                  res_in   = '{outcome: OUT_TASK, collected_task: scan_addr[9:0],
                               was_reordered: 1'b1};
               end
            end else begin
               off_in = off_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               clr_rsp_in   = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         head_ff      <= '0;
         rcnt_ff      <= '0;
         active_ff    <= '0;
         off_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_rsp_ff   <= clr_rsp_in;
         head_ff      <= head_in;
         rcnt_ff      <= rcnt_in;
         active_ff    <= active_in;
         off_ff       <= off_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // checks
   a_reorder_is_task: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.was_reordered) |-> (rsp_word.outcome == OUT_TASK))
      else $error("reordered flag on a non-task word");

   a_head_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_CLEAR) |-> (head_ff <= active_ff))
      else $error("head past task count");

   a_scan_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN_CHK) |-> (off_ff < OFF_W'(REORDER_WINDOW)))
      else $error("scan beyond reorder window");

   a_count_drop: assert property (@(posedge clock) disable iff (reset)
      (rcnt_ff < $past(rcnt_ff)) |-> ($past(state_ff) == S_IDLE && $past(accept) &&
                                      $past(req_word.operation) == OP_BEGIN))
      else $error("rendered count dropped outside begin frame");

endmodule

`default_nettype wire

[test/testbench.sv]
`default_nettype none

module testbench;
   import ocr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT   = 20000;
   localparam int RANDOM_ITEMS = 1800;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_word;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_word;

   overlap_aware_reorder_collector dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Shadow copy of the collector state
   status_type          shadow_status [MAX_TASKS];
   logic signed [15:0]  shadow_left   [MAX_TASKS];
   logic signed [15:0]  shadow_top    [MAX_TASKS];
   logic signed [15:0]  shadow_right  [MAX_TASKS];
   logic signed [15:0]  shadow_bottom [MAX_TASKS];
   bit                  box_written   [MAX_TASKS];
   int                  shadow_head;
   int                  shadow_rendered;
   int                  shadow_active;

   rsp_type pending_rsp[$];
   int      fail_count = 0;
   int      idle_cycles = 0;

   function automatic bit boxes_touch(int a, int b);
      return shadow_left[a] < shadow_right[b] && shadow_left[b] < shadow_right[a] &&
             shadow_top[a] < shadow_bottom[b] && shadow_top[b] < shadow_bottom[a];
   endfunction

   // Work out the answer to one command and advance the shadow state
   function automatic rsp_type collect_step(req_type w);
      rsp_type r;
      int      i, j;
      bit      clear;
      r.outcome = OUT_ACCEPT;
      r.collected_task = '0;
      r.was_reordered = 1'b0;
      case (w.operation)
         OP_BEGIN: begin
            shadow_active = (w.frame_task_count > MAX_TASKS) ? MAX_TASKS : w.frame_task_count;
            foreach (shadow_status[k]) shadow_status[k] = ST_RENDERING;
            shadow_head = 0;
            shadow_rendered = 0;
         end
         OP_LOAD: begin
            shadow_left[w.task_index]   = w.box_left;
            shadow_top[w.task_index]    = w.box_top;
            shadow_right[w.task_index]  = w.box_right;
            shadow_bottom[w.task_index] = w.box_bottom;
            box_written[w.task_index]   = 1'b1;
         end
         OP_MARK: begin
            if (w.task_index < shadow_active) begin
               shadow_status[w.task_index] = ST_RENDERED;
               if (shadow_rendered < COUNT_MAX) shadow_rendered++;
            end
         end
         default: begin
            while (shadow_head < shadow_active && shadow_status[shadow_head] == ST_COLLECTED)
               shadow_head++;
            if (shadow_head >= shadow_active) begin
               r.outcome = OUT_RANGE;
            end else if (shadow_status[shadow_head] == ST_RENDERED) begin
               shadow_status[shadow_head] = ST_COLLECTED;
               r.outcome = OUT_TASK;
               r.collected_task = shadow_head[9:0];
               shadow_head++;
            end else begin
               r.outcome = OUT_NONE;
               if (shadow_rendered > shadow_head &&
                   shadow_rendered <= shadow_head + REORDER_WINDOW) begin
                  for (i = shadow_head; i < shadow_head + REORDER_WINDOW && i < shadow_active;
                       i++) begin
                     if (shadow_status[i] == ST_RENDERED) begin
                        clear = 1'b1;
                        for (j = shadow_head; j < i; j++)
                           if (boxes_touch(j, i)) begin
                              clear = 1'b0;
                              break;
                           end
                        if (clear) begin
                           shadow_status[i] = ST_COLLECTED;
                           r.outcome = OUT_TASK;
                           r.collected_task = i[9:0];
                           r.was_reordered = 1'b1;
                        end
                        break;
                     end
                  end
               end
            end
         end
      endcase
      return r;
   endfunction

   // Sender burst/gap shaping
   int burst_left;

   task automatic send_word(req_type w, bit typed, rsp_type typed_rsp);
      rsp_type predicted;
      int      gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      predicted = collect_step(w);
      pending_rsp.insert(pending_rsp.size(), typed ? typed_rsp : predicted);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 8);
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   function automatic req_type box_word(int idx);
      req_type w;
      int      l, t;
      w = '0;
      w.operation = OP_LOAD;
      w.task_index = idx[9:0];
      if ($urandom_range(0, 9) == 0) begin
         w.box_left = 16'($urandom); w.box_top = 16'($urandom);
         w.box_right = 16'($urandom); w.box_bottom = 16'($urandom);
      end else begin
         l = $urandom_range(0, 60) - 30;
         t = $urandom_range(0, 60) - 30;
         w.box_left = 16'(l); w.box_right = 16'(l + $urandom_range(0, 24));
         w.box_top = 16'(t);  w.box_bottom = 16'(t + $urandom_range(0, 24));
      end
      w.frame_task_count = 11'($urandom);
      return w;
   endfunction

   // Loads any unwritten box a consume could compare, then sends the word
   task automatic issue(req_type w, bit typed, rsp_type typed_rsp);
      int h;
      if (w.operation == OP_CONSUME) begin
         h = shadow_head;
         while (h < shadow_active && shadow_status[h] == ST_COLLECTED) h++;
         for (int i = h; i < h + REORDER_WINDOW && i < shadow_active; i++)
            if (!box_written[i]) send_word(box_word(i), 1'b0, '0);
      end
      send_word(w, typed, typed_rsp);
   endtask

   function automatic req_type cmd(op_type op, int idx, int cnt);
      req_type w;
      w = '0;
      w.operation = op;
      w.task_index = idx[9:0];
      w.frame_task_count = cnt[10:0];
      return w;
   endfunction

   // Directed table
   typedef struct {
      req_type word;
      bit      typed;
      rsp_type answer;
   } row_type;

   localparam rsp_type ACK = '{OUT_ACCEPT, 10'd0, 1'b0};
   localparam rsp_type BAD = '{OUT_RANGE, 10'd0, 1'b0};

   row_type dir_rows[$];

   task automatic add_row(req_type w, bit typed, rsp_type a);
      row_type r;
      r.word = w; r.typed = typed; r.answer = a;
      dir_rows.insert(dir_rows.size(), r);
   endtask

   // Result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected word %p", $time, rsp_word);
            fail_count++;
         end else begin
            rsp_type e;
            e = pending_rsp.pop_front();
            if (rsp_word.outcome !== e.outcome)
               $display("%0t: outcome expected %0d actual %0d", $time, e.outcome,
                        rsp_word.outcome);
            if (rsp_word.collected_task !== e.collected_task)
               $display("%0t: task expected %0d actual %0d", $time, e.collected_task,
                        rsp_word.collected_task);
            if (rsp_word.was_reordered !== e.was_reordered)
               $display("%0t: reordered expected %0d actual %0d", $time, e.was_reordered,
                        rsp_word.was_reordered);
            if (rsp_word !== e) fail_count++;
         end
      end
   end

   // Receiver stall pattern: calm, choppy and long-hold phases
   int stall_mode = 0;
   int stall_span = 0;
   always @(negedge clock) begin
      if (stall_span == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_span = $urandom_range(10, 80);
      end
      stall_span--;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= 1'($urandom_range(0, 1));
         default: rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // Watchdog on handshake progress
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles = 0;
      else if (++idle_cycles >= IDLE_LIMIT) begin
         $display("** overlap_aware_reorder_collector: FAILED **");
         $finish;
      end
   end

   initial begin
      req_type w;
      int      n, frame_len, mark_ptr, sent, r;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      burst_left = 0;
      foreach (shadow_status[k]) begin
         shadow_status[k] = ST_RENDERING;
         box_written[k] = 1'b0;
      end
      shadow_head = 0; shadow_rendered = 0; shadow_active = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Extremes, saturation, repeated marks, out of range cases
      add_row(cmd(OP_CONSUME, 0, 0), 1, BAD);
      add_row(cmd(OP_BEGIN, 0, 2047), 1, ACK);
      w = cmd(OP_LOAD, 0, 0);
      w.box_left = 16'sh8000; w.box_top = 16'sh8000;
      w.box_right = 16'sh7fff; w.box_bottom = 16'sh7fff;
      add_row(w, 1, ACK);
      w = cmd(OP_LOAD, 1023, 2047);
      w.box_left = 16'sh7fff; w.box_top = 16'sh7fff;
      w.box_right = 16'sh8000; w.box_bottom = 16'sh8000;
      add_row(w, 1, ACK);
      add_row(cmd(OP_MARK, 1023, 0), 1, ACK);
      add_row(cmd(OP_MARK, 2, 0), 1, ACK);
      add_row(cmd(OP_CONSUME, 0, 0), 0, ACK);
      add_row(cmd(OP_MARK, 0, 0), 1, ACK);
      add_row(cmd(OP_CONSUME, 0, 0), 0, ACK);
      add_row(cmd(OP_CONSUME, 0, 0), 0, ACK);
      add_row(cmd(OP_BEGIN, 0, 0), 1, ACK);
      add_row(cmd(OP_MARK, 0, 0), 1, ACK);
      add_row(cmd(OP_CONSUME, 0, 0), 1, BAD);
      add_row(cmd(OP_BEGIN, 0, 1025), 1, ACK);
      add_row(cmd(OP_BEGIN, 0, 3), 1, ACK);
      add_row(cmd(OP_MARK, 0, 0), 1, ACK);
      add_row(cmd(OP_MARK, 0, 0), 1, ACK);
      add_row(cmd(OP_MARK, 3, 0), 1, ACK);
      add_row(cmd(OP_CONSUME, 0, 0), 0, ACK);
      add_row(cmd(OP_MARK, 0, 0), 1, ACK);
      add_row(cmd(OP_CONSUME, 0, 0), 0, ACK);
      add_row(cmd(OP_MARK, 2, 0), 1, ACK);
      add_row(cmd(OP_CONSUME, 0, 0), 0, ACK);
      add_row(cmd(OP_MARK, 1, 0), 1, ACK);
      add_row(cmd(OP_CONSUME, 0, 0), 0, ACK);
      foreach (dir_rows[k]) issue(dir_rows[k].word, dir_rows[k].typed, dir_rows[k].answer);

      // Random frames: mostly well-formed with some noise
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         r = $urandom_range(0, 19);
         n = (r == 0) ? 1024 : (r == 1) ? $urandom_range(1025, 2047) :
             (r == 2) ? 0 : $urandom_range(1, 24);
         w = cmd(OP_BEGIN, 0, n);
         w.task_index = 10'($urandom);
         issue(w, 0, ACK);
         sent++;
         n = (n > MAX_TASKS) ? MAX_TASKS : n;
         frame_len = $urandom_range(10, 80);
         mark_ptr = 0;
         for (int k = 0; k < frame_len; k++) begin
            r = $urandom_range(0, 99);
            if (r < 38) begin
               w = cmd(OP_MARK, (mark_ptr + $urandom_range(0, 9)) % 1024, $urandom);
               if ($urandom_range(0, 15) == 0) w.task_index = 10'($urandom);
               mark_ptr++;
            end else if (r < 80) begin
               w = cmd(OP_CONSUME, $urandom, $urandom);
            end else if (r < 95) begin
               w = box_word($urandom_range(0, n + 8) % 1024);
            end else begin
               w = req_type'(($bits(req_type))'($urandom));
               w.frame_task_count = 11'($urandom);
               if (w.operation == OP_BEGIN) w.operation = OP_CONSUME;
            end
            issue(w, 0, ACK);
            sent++;
         end
         // Let the pipeline drain at frame ends near mid-run
         if (sent > RANDOM_ITEMS / 2 && sent < RANDOM_ITEMS / 2 + 90) begin
            @(negedge clock);
            req_valid <= 1'b0;
            while (pending_rsp.size() != 0) @(posedge clock);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending_rsp.size() == 0)
         $display("** overlap_aware_reorder_collector: PASSED **");
      else
         $display("** overlap_aware_reorder_collector: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire

[sim.f]
rtl/ocr_pkg.sv
rtl/ocr_ram.sv
rtl/ocr_window.sv
rtl/overlap_aware_reorder_collector.sv
test/testbench.sv
